// ----- design/rotated_array_search_unit_macros.svh -----
// assertion macros for the rotated array search unit
`ifndef ROTATED_ARRAY_SEARCH_UNIT_MACROS_SVH
`define ROTATED_ARRAY_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RAS_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RAS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/ras_pkg.sv -----
// shared widths, codes and types of the rotated array search unit
`timescale 1ns / 1ps

package ras_pkg;

  localparam int DEPTH       = 1024;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int IDX_W       = ADDR_W + 2;
  localparam int CNT_W       = 11;
  localparam int INDEX_W     = 10;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 10;
  localparam int IN_TDATA_W  = ((INDEX_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } ras_result_t;

endpackage

// ----- design/ras_ram.sv -----
// single-port-write, registered-read memory
`timescale 1ns / 1ps

module ras_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ras_ctrl.sv -----
// search sequencer: pivot bisection and binary search over the element memory
`timescale 1ns / 1ps
`include "rotated_array_search_unit_macros.svh"

module ras_ctrl
  import ras_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CNT_W-1:0]          cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [INDEX_W-1:0]        in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      mem_we,
  output logic [ADDR_W-1:0]         mem_waddr,
  output logic [VALUE_W-1:0]        mem_wdata,
  output logic [ADDR_W-1:0]         mem_raddr,
  input  logic [VALUE_W-1:0]        mem_rdata,
  output logic                      res_valid,
  input  logic                      res_ready,
  output ras_result_t               res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_LOOP,
    S_P_M,
    S_P_N,
    S_P_P,
    S_P_L,
    S_V_0,
    S_B_LOOP,
    S_B_CHK,
    S_RES
  } state_t;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          count;
  logic signed [IDX_W-1:0]   lo, lo_next;
  logic signed [IDX_W-1:0]   hi, hi_next;
  logic signed [IDX_W-1:0]   mid, mid_next;
  logic signed [IDX_W-1:0]   pivot, pivot_next;
  logic signed [IDX_W-1:0]   nm1, nm1_next;
  logic signed [VALUE_W-1:0] vm, vm_next;
  logic signed [VALUE_W-1:0] target, target_next;
  ras_result_t               res_next;

  logic signed [IDX_W-1:0]   n_sat;
  logic signed [IDX_W-1:0]   span_sum;
  logic signed [IDX_W-1:0]   mid_calc;
  logic signed [IDX_W-1:0]   mid_inc;
  logic signed [IDX_W-1:0]   mid_dec;
  logic signed [VALUE_W-1:0] rd;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RES);
  assign rd        = mem_rdata;

  assign n_sat    = (IDX_W'(count) > IDX_W'(DEPTH)) ? IDX_W'(DEPTH) : IDX_W'(count);
  assign span_sum = lo + hi;
  assign mid_calc = span_sum >>> 1;
  assign mid_inc  = mid + IDX_W'(1);
  assign mid_dec  = mid - IDX_W'(1);

  assign mem_we    = in_valid && in_ready && (in_op == OP_WRITE)
                     && (32'(in_index) < 32'(DEPTH));
  assign mem_waddr = ADDR_W'(in_index);
  assign mem_wdata = in_value;

  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    pivot_next  = pivot;
    nm1_next    = nm1;
    vm_next     = vm;
    target_next = target;
    res_next    = res;
    mem_raddr   = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_op == OP_SEARCH) begin
          target_next = in_value;
          lo_next     = '0;
          hi_next     = n_sat - IDX_W'(1);
          nm1_next    = n_sat - IDX_W'(1);
          state_next  = S_P_LOOP;
        end
      end
      S_P_LOOP: begin
        if (lo > hi) begin
          lo_next    = '0;
          hi_next    = nm1;
          state_next = S_B_LOOP;
        end else begin
          mid_next   = mid_calc;
          mem_raddr  = ADDR_W'(mid_calc);
          state_next = S_P_M;
        end
      end
      S_P_M: begin
        vm_next = rd;
        if (mid < hi) begin
          mem_raddr  = ADDR_W'(mid_inc);
          state_next = S_P_N;
        end else if (mid > lo) begin
          mem_raddr  = ADDR_W'(mid_dec);
          state_next = S_P_P;
        end else begin
          mem_raddr  = ADDR_W'(lo);
          state_next = S_P_L;
        end
      end
      S_P_N: begin
        if (vm > rd) begin
          pivot_next = mid;
          if (vm == target) begin
            res_next.found    = 1'b1;
            res_next.position = POS_W'(mid);
            state_next        = S_RES;
          end else begin
            mem_raddr  = '0;
            state_next = S_V_0;
          end
        end else if (mid > lo) begin
          mem_raddr  = ADDR_W'(mid_dec);
          state_next = S_P_P;
        end else begin
          mem_raddr  = ADDR_W'(lo);
          state_next = S_P_L;
        end
      end
      S_P_P: begin
        if (vm < rd) begin
          pivot_next = mid_dec;
          if (rd == target) begin
            res_next.found    = 1'b1;
            res_next.position = POS_W'(mid_dec);
            state_next        = S_RES;
          end else begin
            mem_raddr  = '0;
            state_next = S_V_0;
          end
        end else begin
          mem_raddr  = ADDR_W'(lo);
          state_next = S_P_L;
        end
      end
      S_P_L: begin
        if (rd >= vm) begin
          hi_next = mid_dec;
        end else begin
          lo_next = mid_inc;
        end
        state_next = S_P_LOOP;
      end
      S_V_0: begin
        if (rd <= target) begin
          lo_next = '0;
          hi_next = pivot;
        end else begin
          lo_next = pivot + IDX_W'(1);
          hi_next = nm1;
        end
        state_next = S_B_LOOP;
      end
      S_B_LOOP: begin
        if (lo > hi) begin
          res_next.found    = 1'b0;
          res_next.position = '0;
          state_next        = S_RES;
        end else begin
          mid_next   = mid_calc;
          mem_raddr  = ADDR_W'(mid_calc);
          state_next = S_B_CHK;
        end
      end
      S_B_CHK: begin
        if (rd == target) begin
          res_next.found    = 1'b1;
          res_next.position = POS_W'(mid);
          state_next        = S_RES;
        end else begin
          if (rd < target) begin
            lo_next = mid_inc;
          end else begin
            hi_next = mid_dec;
          end
          state_next = S_B_LOOP;
        end
      end
      S_RES: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        count <= cfg_wr_data;
      end
    end
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    pivot  <= pivot_next;
    nm1    <= nm1_next;
    vm     <= vm_next;
    target <= target_next;
    res    <= res_next;
  end

  `RAS_ASSERT_SAME(a_miss_pos_zero, res_valid && !res.found, res.position == '0, "miss with nonzero position")
  `RAS_ASSERT_SAME(a_no_write_busy, state != S_IDLE, !mem_we, "memory written during a search")
  `RAS_ASSERT_SAME(a_window_open, state == S_P_M || state == S_B_CHK, lo <= hi, "probe outside window")
  `RAS_ASSERT_NEXT(a_search_starts, in_valid && in_ready && in_op == OP_SEARCH, state == S_P_LOOP, "search not started")

endmodule

// ----- design/rotated_array_search_unit.sv -----
// top level of the rotated array search unit
//
//   port group      dir  contents
//   s_axis          in   tuser: op; tdata: index [9:0], value [41:10]
//   m_axis          out  tuser: found; tdata: position [9:0]
//   cfg_wr_en/data  in   element_count
//
// a search runs a pivot bisection and then a binary search, paced by the single read
// port of the element memory (one read per cycle)
// rst clears the sequencer state, the output valid flag and element_count; memory and output data are not cleared
// a finished result waits in the sequencer while the output register is full and m_axis_tready is low;
// new items are accepted while a result waits in the output register
`timescale 1ns / 1ps

module rotated_array_search_unit
  import ras_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // index, value, zero pad
  input  logic                   s_axis_tuser,  // op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // position, zero pad
  output logic                   m_axis_tuser   // found
);

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;
  logic               res_valid;
  logic               res_ready;
  ras_result_t        res;
  ras_result_t        out_res;

  ras_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ras_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser),
    .in_index    (s_axis_tdata[INDEX_W-1:0]),
    .in_value    (s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(out_res.position);
  assign m_axis_tuser = out_res.found;

endmodule
